### rtl/nnts_pkg.sv
// Shared types and constants for the nearest-neighbor thumbnail scaler.
// Used by the channel interfaces, the controller, the datapath and the divider.
package nnts_pkg;

    localparam int DIM_W     = 10;          // image dimension fields
    localparam int PIX_W     = 32;          // one RGBA / BGRA pixel
    localparam int DIV_W     = 2 * DIM_W;   // divider dividend width
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] FALLBACK_WIDTH = DIM_W'(160);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_WIDTH  = 1'b0,
        REG_DEFAULT_WIDTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    // Step of the end-of-frame size calculation
    typedef enum logic [2:0] {
        FIN_NONE = 3'd0,
        FIN_SIZE = 3'd1,
        FIN_DIV1 = 3'd2,
        FIN_DIV2 = 3'd3,
        FIN_DIV3 = 3'd4,
        FIN_QHW  = 3'd5,
        FIN_DONE = 3'd6
    } fin_t;

    typedef struct packed {
        logic load;        // store one source pixel
        logic emit_read;   // read the next output pixel, advance the scan
        logic emit_none;   // post a no-data result
        logic emit_out;    // post the pixel read in the previous cycle
        logic div_start;
        fin_t fin;
    } cmd_t;

    typedef struct packed {
        logic frame_ready;
        logic last_load;   // the offered load item completes the frame
        logic div_done;
        logic out_free;    // result register can take a result this cycle
    } status_t;

    function automatic logic [PIX_W-1:0] rgba_to_bgra(input logic [PIX_W-1:0] p);
        return {p[31:24], p[7:0], p[15:8], p[23:16]};
    endfunction

endpackage

### rtl/nnts_if.sv
// Request and result channel interfaces of the thumbnail scaler.
// Depends on nnts_pkg for field widths.
interface nnts_req_if;
    import nnts_pkg::*;
    logic             valid;
    logic             ready;
    logic             op;
    logic [DIM_W-1:0] img_width;
    logic [DIM_W-1:0] img_height;
    logic [PIX_W-1:0] pixel_rgba;

    modport source (output valid, op, img_width, img_height, pixel_rgba, input ready);
    modport sink   (input valid, op, img_width, img_height, pixel_rgba, output ready);
endinterface

interface nnts_rsp_if;
    import nnts_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_bgra;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic             last_pixel;
    logic             no_data;

    modport source (output valid, pixel_bgra, out_width, out_height, last_pixel, no_data,
                    input ready);
    modport sink   (input valid, pixel_bgra, out_width, out_height, last_pixel, no_data,
                    output ready);
endinterface

### rtl/nnts_div.sv
// Restoring divider, one quotient bit per cycle, for the frame size setup.
// Depends on nnts_pkg for widths.
module nnts_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nnts_pkg::DIV_W-1:0]  dividend,
    input  logic [nnts_pkg::DIM_W-1:0]  divisor,
    output logic                        done,
    output logic [nnts_pkg::DIM_W-1:0]  quotient,
    output logic [nnts_pkg::DIM_W-1:0]  remainder
);
    import nnts_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIM_W-1:0]     dsr_reg;
    logic [DIM_W:0]       trial;
    logic [DIM_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign done  = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg[DIM_W-1:0];
    assign remainder = rem_reg;

endmodule

### rtl/nnts_ctrl.sv
// Sequencer of the thumbnail scaler: request acceptance, emit read and
// end-of-frame size setup. Depends on nnts_pkg for command/status types.
module nnts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_ready,
    input  nnts_pkg::status_t st,
    output nnts_pkg::cmd_t    cmd
);
    import nnts_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_SIZE = 8'b0000_0100,
        S_DIV1 = 8'b0000_1000,
        S_DIV2 = 8'b0001_0000,
        S_DIV3 = 8'b0010_0000,
        S_QHW  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   run_reg, run_next;
    logic   xfer;

    assign req_ready = (state_reg == S_IDLE) && st.out_free;
    assign xfer      = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.fin    = FIN_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (xfer)
                begin
                    if (req_op == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (st.last_load)
                            state_next = S_SIZE;
                    end
                    else if (st.frame_ready)
                    begin
                        cmd.emit_read = 1'b1;
                        state_next    = S_READ;
                    end
                    else
                        cmd.emit_none = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.emit_out = 1'b1;
                state_next   = S_IDLE;
            end
            S_SIZE:
            begin
                cmd.fin    = FIN_SIZE;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.fin       = FIN_DIV1;
                cmd.div_start = !run_reg;
                if (st.div_done)
                    state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.fin       = FIN_DIV2;
                cmd.div_start = !run_reg;
                if (st.div_done)
                    state_next = S_DIV3;
            end
            S_DIV3:
            begin
                cmd.fin       = FIN_DIV3;
                cmd.div_start = !run_reg;
                if (st.div_done)
                    state_next = S_QHW;
            end
            S_QHW:
            begin
                cmd.fin    = FIN_QHW;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.fin    = FIN_DONE;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Track whether the divider was launched in the current divide state
    always_comb
    begin
        run_next = run_reg;
        if (st.div_done)
            run_next = 1'b0;
        else if (cmd.div_start)
            run_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

endmodule

### rtl/nnts_dp.sv
// Datapath of the thumbnail scaler: config registers, frame store, size
// setup, source index stepping and result register. Depends on nnts_pkg, nnts_div.
module nnts_dp #(
    parameter int MAX_DIM = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nnts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nnts_pkg::DIM_W-1:0]    cfg_data,
    input  logic [nnts_pkg::DIM_W-1:0]    img_width,
    input  logic [nnts_pkg::DIM_W-1:0]    img_height,
    input  logic [nnts_pkg::PIX_W-1:0]    pixel_rgba,
    input  nnts_pkg::cmd_t                cmd,
    output nnts_pkg::status_t             st,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [nnts_pkg::PIX_W-1:0]    pixel_bgra,
    output logic [nnts_pkg::DIM_W-1:0]    out_width,
    output logic [nnts_pkg::DIM_W-1:0]    out_height,
    output logic                          last_pixel,
    output logic                          no_data
);
    import nnts_pkg::*;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (int'(d) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    logic [PIX_W-1:0] mem [STORE_DEPTH];

    // configuration
    logic [DIM_W-1:0] target_w_reg, default_w_reg;
    logic [DIM_W-1:0] cap;

    // frame load
    logic [CNT_W-1:0] load_count_reg, cnt_inc, total_reg;
    logic [DIM_W-1:0] src_w_reg, src_h_reg, w_in, h_in;
    logic             first_load;
    logic             frame_ready_reg;

    // size setup
    logic [DIM_W-1:0] cap_reg;
    logic             wide_reg, wide;
    logic [DIV_W-1:0] prod_reg;
    logic [DIM_W-1:0] scaled_w_reg, scaled_h_reg;
    logic [DIM_W-1:0] qw_reg, rw_reg, rh_reg;
    logic [CNT_W-1:0] qhw_reg, qhwp_reg;
    logic [DIV_W-1:0] div_dividend;
    logic [DIM_W-1:0] div_divisor, div_quo, div_rem;
    logic             div_done;

    // output scan
    logic [DIM_W-1:0] col_reg, row_reg, sx_q_reg, sx_r_reg, sy_r_reg;
    logic [CNT_W-1:0] row_base_reg, rd_addr;
    logic             col_end, row_end, last_px;
    logic [DIM_W:0]   sx_sum, sy_sum;
    logic             sx_carry, sy_carry;
    logic [PIX_W-1:0] rd_reg;
    logic             last_rd_reg;
    logic             out_valid_reg, out_valid_next;

    // result register
    logic [PIX_W-1:0] pix_out_reg;
    logic [DIM_W-1:0] ow_out_reg, oh_out_reg;
    logic             last_out_reg, none_out_reg;

    always_comb
    begin
        if (target_w_reg != '0)
            cap = target_w_reg;
        else if (default_w_reg != '0)
            cap = default_w_reg;
        else
            cap = FALLBACK_WIDTH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_w_reg  <= '0;
            default_w_reg <= FALLBACK_WIDTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_WIDTH:  target_w_reg  <= cfg_data;
                REG_DEFAULT_WIDTH: default_w_reg <= cfg_data;
            endcase
        end
    end

    // ---------------------------------------------------------------- load
    assign first_load = (load_count_reg == '0);
    assign w_in       = clamp_dim(img_width);
    assign h_in       = clamp_dim(img_height);
    assign cnt_inc    = load_count_reg + 1'b1;

    assign st.last_load = first_load ? (w_in == DIM_W'(1) && h_in == DIM_W'(1))
                                     : (cnt_inc >= total_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[load_count_reg[ADDR_W-1:0]] <= pixel_rgba;
        if (cmd.emit_read)
            rd_reg <= mem[rd_addr[ADDR_W-1:0]];
    end

    // ---------------------------------------------------------- size setup
    assign wide = src_w_reg > cap_reg;

    always_comb
    begin
        unique case (cmd.fin)
            FIN_DIV2:
            begin
                div_dividend = DIV_W'(src_w_reg);
                div_divisor  = scaled_w_reg;
            end
            FIN_DIV3:
            begin
                div_dividend = DIV_W'(src_h_reg);
                div_divisor  = scaled_h_reg;
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = src_w_reg;
            end
        endcase
    end

    nnts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign st.div_done = div_done;

    // Payload side of the size setup; quotients are picked up as the next
    // division is launched, before the divider overwrites them.
    always_ff @(posedge clk)
    begin
        if (cmd.load && st.last_load)
            cap_reg <= cap;
        if (cmd.load && first_load)
            total_reg <= CNT_W'(w_in * h_in);
        unique case (cmd.fin)
            FIN_SIZE:
            begin
                prod_reg <= src_h_reg * cap_reg;
                wide_reg <= wide;
            end
            FIN_DIV3:
            begin
                if (cmd.div_start)
                begin
                    qw_reg <= div_quo;
                    rw_reg <= div_rem;
                end
            end
            FIN_QHW:
            begin
                rh_reg  <= div_rem;
                qhw_reg <= CNT_W'(div_quo * src_w_reg);
            end
            FIN_DONE:
                qhwp_reg <= qhw_reg + CNT_W'(src_w_reg);
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------ emit scan
    assign rd_addr  = row_base_reg + CNT_W'(sx_q_reg);
    assign col_end  = ({1'b0, col_reg} + 1'b1) >= {1'b0, scaled_w_reg};
    assign row_end  = ({1'b0, row_reg} + 1'b1) >= {1'b0, scaled_h_reg};
    assign last_px  = col_end && row_end;
    assign sx_sum   = {1'b0, sx_r_reg} + {1'b0, rw_reg};
    assign sx_carry = sx_sum >= {1'b0, scaled_w_reg};
    assign sy_sum   = {1'b0, sy_r_reg} + {1'b0, rh_reg};
    assign sy_carry = sy_sum >= {1'b0, scaled_h_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg  <= '0;
            src_w_reg       <= DIM_W'(1);
            src_h_reg       <= DIM_W'(1);
            scaled_w_reg    <= DIM_W'(1);
            scaled_h_reg    <= DIM_W'(1);
            frame_ready_reg <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            sx_q_reg        <= '0;
            sx_r_reg        <= '0;
            sy_r_reg        <= '0;
            row_base_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (first_load)
                begin
                    src_w_reg       <= w_in;
                    src_h_reg       <= h_in;
                    frame_ready_reg <= 1'b0;
                end
                load_count_reg <= st.last_load ? '0 : cnt_inc;
            end

            if (cmd.fin == FIN_SIZE)
                scaled_w_reg <= wide ? cap_reg : src_w_reg;

            if (cmd.fin == FIN_DIV2 && cmd.div_start)
            begin
                if (!wide_reg)
                    scaled_h_reg <= src_h_reg;
                else if (div_quo == '0)
                    scaled_h_reg <= DIM_W'(1);
                else
                    scaled_h_reg <= div_quo;
            end

            if (cmd.fin == FIN_DONE)
            begin
                frame_ready_reg <= 1'b1;
                col_reg         <= '0;
                row_reg         <= '0;
                sx_q_reg        <= '0;
                sx_r_reg        <= '0;
                sy_r_reg        <= '0;
                row_base_reg    <= '0;
            end

            if (cmd.emit_read)
            begin
                priority if (last_px)
                begin
                    frame_ready_reg <= 1'b0;
                    col_reg         <= '0;
                    row_reg         <= '0;
                    sx_q_reg        <= '0;
                    sx_r_reg        <= '0;
                    sy_r_reg        <= '0;
                    row_base_reg    <= '0;
                end
                else if (col_end)
                begin
                    // wrap to the next row, step the source row base
                    col_reg      <= '0;
                    row_reg      <= row_reg + 1'b1;
                    sx_q_reg     <= '0;
                    sx_r_reg     <= '0;
                    sy_r_reg     <= sy_carry ? DIM_W'(sy_sum - {1'b0, scaled_h_reg})
                                             : sy_sum[DIM_W-1:0];
                    row_base_reg <= row_base_reg + (sy_carry ? qhwp_reg : qhw_reg);
                end
                else
                begin
                    col_reg  <= col_reg + 1'b1;
                    sx_q_reg <= sx_q_reg + qw_reg + DIM_W'(sx_carry);
                    sx_r_reg <= sx_carry ? DIM_W'(sx_sum - {1'b0, scaled_w_reg})
                                         : sx_sum[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_read)
            last_rd_reg <= last_px;
    end

    assign st.frame_ready = frame_ready_reg;

    // --------------------------------------------------------- result stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_out || cmd.emit_none)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_none)
        begin
            pix_out_reg  <= '0;
            last_out_reg <= 1'b0;
            none_out_reg <= 1'b1;
            ow_out_reg   <= scaled_w_reg;
            oh_out_reg   <= scaled_h_reg;
        end
        else if (cmd.emit_out)
        begin
            pix_out_reg  <= rgba_to_bgra(rd_reg);
            last_out_reg <= last_rd_reg;
            none_out_reg <= 1'b0;
            ow_out_reg   <= scaled_w_reg;
            oh_out_reg   <= scaled_h_reg;
        end
    end

    assign pixel_bgra  = pix_out_reg;
    assign last_pixel  = last_out_reg;
    assign no_data     = none_out_reg;
    assign out_width   = ow_out_reg;
    assign out_height  = oh_out_reg;
    assign out_valid   = out_valid_reg;
    assign st.out_free = !out_valid_reg || out_ready;

endmodule

### rtl/nearest_neighbor_thumbnail_scaler.sv
// Nearest-neighbor thumbnail scaler, top level.
// Depends on nnts_pkg, nnts_if, nnts_ctrl, nnts_dp.
//
// Usage:
//   req carries one item per transfer. op = load stores pixel_rgba at the
//   next raster position of the frame store; the first load of a frame
//   samples img_width / img_height. op = emit asks for the next output
//   pixel, which comes back on rsp in BGRA order with the scaled frame
//   size, last_pixel on the final pixel, or no_data when nothing is pending.
//   cfg_we / cfg_index / cfg_data write target_width and default_width;
//   the width cap is sampled with the last load of a frame.
// Sequencing:
//   A load stores its pixel as it is accepted; loads can follow back to back.
//   The load that completes a frame starts the size setup: a multiply step,
//   three divisions (launch plus radix-2 steps in the shared divider) and
//   two short steps, with req.ready low.
//   An emit reads the frame store, then writes the result register; a no-data
//   emit writes the result register directly. The result register drives rsp.
// Reset clears all control state; the frame store is not cleared and no
//   frame is pending. While rsp is stalled with a result held, req.ready
//   stays low; the result holds until rsp.ready.
module nearest_neighbor_thumbnail_scaler #(
    parameter int MAX_DIM = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nnts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nnts_pkg::DIM_W-1:0]     cfg_data,
    nnts_req_if.sink                       req,
    nnts_rsp_if.source                     rsp
);
    import nnts_pkg::*;

    cmd_t    cmd;
    status_t st;

    nnts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    nnts_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .img_width  (req.img_width),
        .img_height (req.img_height),
        .pixel_rgba (req.pixel_rgba),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .pixel_bgra (rsp.pixel_bgra),
        .out_width  (rsp.out_width),
        .out_height (rsp.out_height),
        .last_pixel (rsp.last_pixel),
        .no_data    (rsp.no_data)
    );

endmodule

### rtl/nnts_chk.sv
// Port-level checks for the thumbnail scaler, bound to the top level.
// Depends on nnts_pkg for field widths.
module nnts_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       req_op,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [nnts_pkg::PIX_W-1:0] rsp_pixel,
    input logic                       rsp_last,
    input logic                       rsp_no_data
);
    import nnts_pkg::*;

    logic req_xfer;
    assign req_xfer = req_valid && req_ready;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_last))
        else $error("result changed while stalled");

    // an emit either posts a result at once or blocks requests while reading
    assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req_op == OP_EMIT |=> rsp_valid || !req_ready)
        else $error("emit neither answered nor in progress");

    // a load never causes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req_op == OP_LOAD && !rsp_valid |=> !rsp_valid)
        else $error("load produced a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_no_data |-> rsp_pixel == '0 && !rsp_last)
        else $error("no-data result carries pixel or last flag");

endmodule

bind nearest_neighbor_thumbnail_scaler nnts_chk u_nnts_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_op      (req.op),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_pixel   (rsp.pixel_bgra),
    .rsp_last    (rsp.last_pixel),
    .rsp_no_data (rsp.no_data)
);
